// File: hdl/prtl_pkg.sv
package prtl_pkg;

   localparam int PosWidth   = 32;
   localparam int AngWidth   = 16;
   localparam int MatWidth   = 16;
   localparam int ProdWidth  = PosWidth + MatWidth;
   localparam int DotWidth   = ProdWidth + 1;
   localparam int FracShift  = 14;
   localparam int RotWidth   = DotWidth - FracShift;
   localparam int WideWidth  = RotWidth + 1;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CsrRotXx  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrRotXy  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRotYx  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrRotYy  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrShiftX = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrShiftY = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrYaw    = 3'd6;

   localparam logic signed [MatWidth-1:0] RotUnity = 16'sd16384;
   localparam logic signed [DotWidth-1:0] RoundBias = 49'sd8192;

   typedef struct packed {
      logic                x_limited;
      logic                y_limited;
      logic [AngWidth-1:0] heading;
      logic                heading_limited;
      logic [AngWidth-1:0] heading_low;
      logic [AngWidth-1:0] heading_high;
   } side_type;

   // Sum of two Q.30 products rounded to Q.16, halves toward plus infinity.
   function automatic logic signed [RotWidth-1:0] dot_round(
      input logic signed [ProdWidth-1:0] a,
      input logic signed [ProdWidth-1:0] b
   );
      logic signed [DotWidth-1:0] sum;
      sum = DotWidth'(a) + DotWidth'(b) + RoundBias;
      return sum[DotWidth-1:FracShift];
   endfunction

   function automatic logic [PosWidth-1:0] sat_pos(input logic signed [WideWidth-1:0] v);
      logic [PosWidth-1:0] res;
      if (v > WideWidth'(signed'(33'sh0_7FFF_FFFF))) begin
         res = {1'b0, {(PosWidth-1){1'b1}}};
      end else if (v < WideWidth'(signed'(33'sh1_8000_0000))) begin
         res = {1'b1, {(PosWidth-1){1'b0}}};
      end else begin
         res = v[PosWidth-1:0];
      end
      return res;
   endfunction

endpackage

// File: hdl/pose_rigid_transform_with_limits.sv
// Channel   Direction  Handshake           Contents
// req_      in         req_valid/req_stall point, x/y limits, heading and its limits
// rsp_      out        rsp_valid/rsp_stall transformed point, rotated limit box, heading
// csr_      in         csr_write_en        matrix, translation and yaw registers
//
// A request is taken every cycle while the response side is not stalled.
// The four stages are the input register, the twelve products, the rounded sums and
// the min/max with saturation into the response register.
// A stalled response freezes all four stages together and stalls the request side.
// Reset clears the stage valid bits and loads the identity transform with zero yaw.
module pose_rigid_transform_with_limits
   import prtl_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write_en,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [PosWidth-1:0]           csr_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [PosWidth-1:0]    req_pos_x,
   input  logic signed [PosWidth-1:0]    req_pos_y,
   input  logic                          req_x_limited,
   input  logic                          req_y_limited,
   input  logic signed [PosWidth-1:0]    req_x_low,
   input  logic signed [PosWidth-1:0]    req_x_high,
   input  logic signed [PosWidth-1:0]    req_y_low,
   input  logic signed [PosWidth-1:0]    req_y_high,
   input  logic signed [AngWidth-1:0]    req_heading,
   input  logic                          req_heading_limited,
   input  logic signed [AngWidth-1:0]    req_heading_low,
   input  logic signed [AngWidth-1:0]    req_heading_high,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [PosWidth-1:0]    rsp_out_x,
   output logic signed [PosWidth-1:0]    rsp_out_y,
   output logic                          rsp_out_x_limited,
   output logic                          rsp_out_y_limited,
   output logic signed [PosWidth-1:0]    rsp_out_x_low,
   output logic signed [PosWidth-1:0]    rsp_out_x_high,
   output logic signed [PosWidth-1:0]    rsp_out_y_low,
   output logic signed [PosWidth-1:0]    rsp_out_y_high,
   output logic signed [AngWidth-1:0]    rsp_out_heading,
   output logic                          rsp_out_heading_limited,
   output logic signed [AngWidth-1:0]    rsp_out_heading_low,
   output logic signed [AngWidth-1:0]    rsp_out_heading_high
);

   logic signed [MatWidth-1:0] rot_xx_ff, rot_xy_ff, rot_yx_ff, rot_yy_ff;
   logic signed [PosWidth-1:0] shift_x_ff, shift_y_ff;
   logic [AngWidth-1:0]        yaw_ff;

   logic advance;

   // Stage 1: input register.
   logic                       s1_valid_ff;
   logic signed [PosWidth-1:0] s1_pos_x_ff, s1_pos_y_ff;
   logic signed [PosWidth-1:0] s1_x_low_ff, s1_x_high_ff, s1_y_low_ff, s1_y_high_ff;
   side_type                   s1_side_ff, s1_side_in;

   // Stage 2: products.
   logic                        s2_valid_ff;
   logic signed [ProdWidth-1:0] s2_pt_ff [4];
   logic signed [ProdWidth-1:0] s2_lim_ff [8];
   logic signed [PosWidth-1:0]  s2_x_low_in, s2_x_high_in, s2_y_low_in, s2_y_high_in;
   side_type                    s2_side_ff, s2_side_in;

   // Stage 3: rounded sums.
   logic                        s3_valid_ff;
   logic signed [WideWidth-1:0] s3_pt_x_ff, s3_pt_y_ff;
   logic signed [RotWidth-1:0]  s3_cx_ff [4];
   logic signed [RotWidth-1:0]  s3_cy_ff [4];
   side_type                    s3_side_ff;

   logic signed [RotWidth-1:0]  pt_x_rot, pt_y_rot;

   // Stage 4: response register.
   logic                        rsp_valid_ff;
   logic signed [RotWidth-1:0]  x_min, x_max, y_min, y_max;
   logic signed [RotWidth-1:0]  xa_min, xb_min, xa_max, xb_max;
   logic signed [RotWidth-1:0]  ya_min, yb_min, ya_max, yb_max;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_xx_ff  <= RotUnity;
         rot_xy_ff  <= '0;
         rot_yx_ff  <= '0;
         rot_yy_ff  <= RotUnity;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         yaw_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrRotXx:  rot_xx_ff  <= csr_data[MatWidth-1:0];
            CsrRotXy:  rot_xy_ff  <= csr_data[MatWidth-1:0];
            CsrRotYx:  rot_yx_ff  <= csr_data[MatWidth-1:0];
            CsrRotYy:  rot_yy_ff  <= csr_data[MatWidth-1:0];
            CsrShiftX: shift_x_ff <= csr_data;
            CsrShiftY: shift_y_ff <= csr_data;
            CsrYaw:    yaw_ff     <= csr_data[AngWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      s1_side_in.x_limited       = req_x_limited;
      s1_side_in.y_limited       = req_y_limited;
      s1_side_in.heading         = req_heading;
      s1_side_in.heading_limited = req_heading_limited;
      s1_side_in.heading_low     = req_heading_low;
      s1_side_in.heading_high    = req_heading_high;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pos_x_ff  <= req_pos_x;
         s1_pos_y_ff  <= req_pos_y;
         s1_x_low_ff  <= req_x_low;
         s1_x_high_ff <= req_x_high;
         s1_y_low_ff  <= req_y_low;
         s1_y_high_ff <= req_y_high;
         s1_side_ff   <= s1_side_in;
      end
   end

   // A corner coordinate of an axis without limits counts as zero.
   always_comb begin
      s2_x_low_in  = s1_side_ff.x_limited ? s1_x_low_ff  : '0;
      s2_x_high_in = s1_side_ff.x_limited ? s1_x_high_ff : '0;
      s2_y_low_in  = s1_side_ff.y_limited ? s1_y_low_ff  : '0;
      s2_y_high_in = s1_side_ff.y_limited ? s1_y_high_ff : '0;
      s2_side_in         = s1_side_ff;
      s2_side_in.heading = s1_side_ff.heading + yaw_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pt_ff[0]  <= ProdWidth'(rot_xx_ff) * ProdWidth'(s1_pos_x_ff);
         s2_pt_ff[1]  <= ProdWidth'(rot_xy_ff) * ProdWidth'(s1_pos_y_ff);
         s2_pt_ff[2]  <= ProdWidth'(rot_yx_ff) * ProdWidth'(s1_pos_x_ff);
         s2_pt_ff[3]  <= ProdWidth'(rot_yy_ff) * ProdWidth'(s1_pos_y_ff);
         s2_lim_ff[0] <= ProdWidth'(rot_xx_ff) * ProdWidth'(s2_x_low_in);
         s2_lim_ff[1] <= ProdWidth'(rot_xx_ff) * ProdWidth'(s2_x_high_in);
         s2_lim_ff[2] <= ProdWidth'(rot_xy_ff) * ProdWidth'(s2_y_low_in);
         s2_lim_ff[3] <= ProdWidth'(rot_xy_ff) * ProdWidth'(s2_y_high_in);
         s2_lim_ff[4] <= ProdWidth'(rot_yx_ff) * ProdWidth'(s2_x_low_in);
         s2_lim_ff[5] <= ProdWidth'(rot_yx_ff) * ProdWidth'(s2_x_high_in);
         s2_lim_ff[6] <= ProdWidth'(rot_yy_ff) * ProdWidth'(s2_y_low_in);
         s2_lim_ff[7] <= ProdWidth'(rot_yy_ff) * ProdWidth'(s2_y_high_in);
         s2_side_ff   <= s2_side_in;
      end
   end

   assign pt_x_rot = dot_round(s2_pt_ff[0], s2_pt_ff[1]);
   assign pt_y_rot = dot_round(s2_pt_ff[2], s2_pt_ff[3]);

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_pt_x_ff  <= WideWidth'(pt_x_rot) + WideWidth'(shift_x_ff);
         s3_pt_y_ff  <= WideWidth'(pt_y_rot) + WideWidth'(shift_y_ff);
         s3_cx_ff[0] <= dot_round(s2_lim_ff[0], s2_lim_ff[2]);
         s3_cx_ff[1] <= dot_round(s2_lim_ff[0], s2_lim_ff[3]);
         s3_cx_ff[2] <= dot_round(s2_lim_ff[1], s2_lim_ff[2]);
         s3_cx_ff[3] <= dot_round(s2_lim_ff[1], s2_lim_ff[3]);
         s3_cy_ff[0] <= dot_round(s2_lim_ff[4], s2_lim_ff[6]);
         s3_cy_ff[1] <= dot_round(s2_lim_ff[4], s2_lim_ff[7]);
         s3_cy_ff[2] <= dot_round(s2_lim_ff[5], s2_lim_ff[6]);
         s3_cy_ff[3] <= dot_round(s2_lim_ff[5], s2_lim_ff[7]);
         s3_side_ff  <= s2_side_ff;
      end
   end

   always_comb begin
      xa_min = (s3_cx_ff[1] < s3_cx_ff[0]) ? s3_cx_ff[1] : s3_cx_ff[0];
      xb_min = (s3_cx_ff[3] < s3_cx_ff[2]) ? s3_cx_ff[3] : s3_cx_ff[2];
      xa_max = (s3_cx_ff[1] > s3_cx_ff[0]) ? s3_cx_ff[1] : s3_cx_ff[0];
      xb_max = (s3_cx_ff[3] > s3_cx_ff[2]) ? s3_cx_ff[3] : s3_cx_ff[2];
      ya_min = (s3_cy_ff[1] < s3_cy_ff[0]) ? s3_cy_ff[1] : s3_cy_ff[0];
      yb_min = (s3_cy_ff[3] < s3_cy_ff[2]) ? s3_cy_ff[3] : s3_cy_ff[2];
      ya_max = (s3_cy_ff[1] > s3_cy_ff[0]) ? s3_cy_ff[1] : s3_cy_ff[0];
      yb_max = (s3_cy_ff[3] > s3_cy_ff[2]) ? s3_cy_ff[3] : s3_cy_ff[2];
      x_min  = (xb_min < xa_min) ? xb_min : xa_min;
      x_max  = (xb_max > xa_max) ? xb_max : xa_max;
      y_min  = (yb_min < ya_min) ? yb_min : ya_min;
      y_max  = (yb_max > ya_max) ? yb_max : ya_max;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_out_x               <= sat_pos(s3_pt_x_ff);
         rsp_out_y               <= sat_pos(s3_pt_y_ff);
         rsp_out_x_limited       <= s3_side_ff.x_limited;
         rsp_out_y_limited       <= s3_side_ff.y_limited;
         rsp_out_x_low           <= s3_side_ff.x_limited ? sat_pos(WideWidth'(x_min)) : '0;
         rsp_out_x_high          <= s3_side_ff.x_limited ? sat_pos(WideWidth'(x_max)) : '0;
         rsp_out_y_low           <= s3_side_ff.y_limited ? sat_pos(WideWidth'(y_min)) : '0;
         rsp_out_y_high          <= s3_side_ff.y_limited ? sat_pos(WideWidth'(y_max)) : '0;
         rsp_out_heading         <= s3_side_ff.heading;
         rsp_out_heading_limited <= s3_side_ff.heading_limited;
         rsp_out_heading_low     <= s3_side_ff.heading_low;
         rsp_out_heading_high    <= s3_side_ff.heading_high;
      end
   end

endmodule

// File: hdl/prtl_checker.sv
module prtl_checker
   import prtl_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [PosWidth-1:0] rsp_out_x,
   input logic                       rsp_out_x_limited,
   input logic                       rsp_out_y_limited,
   input logic signed [PosWidth-1:0] rsp_out_x_low,
   input logic signed [PosWidth-1:0] rsp_out_x_high,
   input logic signed [PosWidth-1:0] rsp_out_y_low,
   input logic signed [PosWidth-1:0] rsp_out_y_high
);

   // The pipeline holds no response right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("stalled response changed");

   a_x_unlimited_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_x_limited |-> rsp_out_x_low == '0 && rsp_out_x_high == '0)
      else $error("x limits not zero on an unlimited axis");

   a_y_unlimited_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_y_limited |-> rsp_out_y_low == '0 && rsp_out_y_high == '0)
      else $error("y limits not zero on an unlimited axis");

   // The bounds are the minimum and maximum of the same corners.
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_x_low <= rsp_out_x_high && rsp_out_y_low <= rsp_out_y_high)
      else $error("rotated limit box is inverted");

endmodule

bind pose_rigid_transform_with_limits prtl_checker u_prtl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_x         (rsp_out_x),
   .rsp_out_x_limited (rsp_out_x_limited),
   .rsp_out_y_limited (rsp_out_y_limited),
   .rsp_out_x_low     (rsp_out_x_low),
   .rsp_out_x_high    (rsp_out_x_high),
   .rsp_out_y_low     (rsp_out_y_low),
   .rsp_out_y_high    (rsp_out_y_high)
);
